// ===== rtl/core/fyee_pkg.sv =====
// ----------------------------------------------------------------------------
// fyee_pkg
// Shared constants, types and fixed-point helpers for the 1-D Yee grid stepper.
// ----------------------------------------------------------------------------
package fyee_pkg;

  // Grid size and the address widths that follow from it.
  localparam int unsigned CELLS   = 1024;
  localparam int unsigned HA_W    = $clog2(CELLS);
  localparam int unsigned EA_W    = $clog2(CELLS + 1);
  localparam int unsigned MUL_LAT = 3;

  // Configuration register numbers.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_E_COEFF   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_H_COEFF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MUR_COEFF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_INDEX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRB_INDEX = 3'd4;

  // Reset values: 1.0 in Q8.24, and the default source and probe cell.
  localparam logic signed [31:0] Q_ONE         = 32'sd16777216;
  localparam logic [9:0]         DEFAULT_INDEX = 10'd500;

  typedef struct packed {
    logic signed [31:0] e_coeff;
    logic signed [31:0] h_coeff;
    logic signed [25:0] mur_coeff;
    logic [9:0]         source_index;
    logic [9:0]         probe_index;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] probe_h;
    logic signed [31:0] probe_e;
  } res_t;

  // Control from the top level to the engine.
  typedef struct packed {
    logic start;
    logic take;
  } ctl_t;

  // Status from the engine to the top level.
  typedef struct packed {
    logic ready;
    logic done;
  } stat_t;

  // Saturate a 34-bit sum to 32 bits.
  function automatic logic signed [31:0] sat_sum(input logic signed [33:0] x);
    logic signed [31:0] r;
    if (x[33:31] == 3'b000 || x[33:31] == 3'b111) begin
      r = x[31:0];
    end else if (x[33]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  // Drop 24 fraction bits (floor) from a 65-bit product and saturate to 32 bits.
  function automatic logic signed [31:0] q24_sat(input logic signed [64:0] p);
    logic signed [40:0] s;
    logic signed [31:0] r;
    s = p[64:24];
    if (s[40:31] == 10'h000 || s[40:31] == 10'h3ff) begin
      r = s[31:0];
    end else if (s[40]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/fyee_mulq.sv =====
// ----------------------------------------------------------------------------
// fyee_mulq
// Three-stage Q8.24 multiplier: input register, product register, and a
// floor-and-saturate output register.
// ----------------------------------------------------------------------------
module fyee_mulq (
  input  logic               clk,
  input  logic signed [31:0] coeff,
  input  logic signed [32:0] diff,
  output logic signed [31:0] result
);
  import fyee_pkg::*;

  logic signed [31:0] coeff_q;
  logic signed [32:0] diff_q;
  logic signed [64:0] prod_q;

  always_ff @(posedge clk) begin
    coeff_q <= coeff;
    diff_q  <= diff;
    prod_q  <= 65'(coeff_q) * 65'(diff_q);
    result  <= q24_sat(prod_q);
  end

endmodule

// ===== rtl/core/fyee_engine.sv =====
// ----------------------------------------------------------------------------
// fyee_engine
// Field memories and the per-step sequencer: clearing pass, fused E/H pass,
// Mur boundary tail and probe read-out.
// ----------------------------------------------------------------------------
module fyee_engine (
  input  logic                clk,
  input  logic                rst,
  input  fyee_pkg::cfg_t      cfg,
  input  fyee_pkg::ctl_t      ctl,
  input  logic signed [31:0]  inc_in,
  output fyee_pkg::stat_t     stat,
  output fyee_pkg::res_t      res
);
  import fyee_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CLEAR = 6'b000010,
    ST_PASS  = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_TAIL  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  // Tail schedule, in cycles after the pass has drained.
  localparam logic [3:0] T_MUR0 = 4'd0;
  localparam logic [3:0] T_E0   = 4'd3;
  localparam logic [3:0] T_EC   = 4'd4;
  localparam logic [3:0] T_HD0  = 4'd4;
  localparam logic [3:0] T_H0   = 4'd7;
  localparam logic [3:0] T_HC   = 4'd8;
  localparam logic [3:0] T_OUT  = 4'd10;

  state_t            state;
  logic [EA_W-1:0]   cnt;
  logic [3:0]        tc;
  logic signed [31:0] inc;

  logic [31:0] e_mem [CELLS+1];
  logic [31:0] h_mem [CELLS];

  logic              e_we, h_we;
  logic [EA_W-1:0]   e_waddr, e_raddr;
  logic [HA_W-1:0]   h_waddr, h_raddr;
  logic signed [31:0] e_wdata, h_wdata;
  logic signed [31:0] e_rdata, h_rdata;

  // Read-side pipeline.
  logic              rv_q;
  logic [EA_W-1:0]   ridx_q;
  logic              v1;
  logic [EA_W-1:0]   idx1;
  logic signed [31:0] hp1, eo1, hp_prev;
  logic signed [31:0] hp_c;

  // E-side delay line alongside the multiplier.
  logic              de_v   [MUL_LAT];
  logic [EA_W-1:0]   de_idx [MUL_LAT];
  logic signed [31:0] de_eo [MUL_LAT];
  logic signed [31:0] de_hk [MUL_LAT];
  logic signed [31:0] en_c;

  logic              vf;
  logic [EA_W-1:0]   idxf;
  logic signed [31:0] enf, hkf, en_prev;

  // H-side delay line.
  logic              dh_v   [MUL_LAT];
  logic [EA_W-1:0]   dh_idx [MUL_LAT];
  logic signed [31:0] dh_hk [MUL_LAT];
  logic signed [31:0] hn_c;

  // Boundary values and Mur history.
  logic signed [31:0] h0p, hcm1p, e1n, ecm1n, e0n, ecn;
  logic signed [31:0] hist [4];

  logic signed [31:0] me_coeff, mh_coeff, m_e, m_h;
  logic signed [32:0] me_diff, mh_diff;
  logic              busy;

  fyee_mulq u_mul_e (.clk(clk), .coeff(me_coeff), .diff(me_diff), .result(m_e));
  fyee_mulq u_mul_h (.clk(clk), .coeff(mh_coeff), .diff(mh_diff), .result(m_h));

  assign stat.ready = (state == ST_IDLE);
  assign stat.done  = (state == ST_DONE);

  assign busy = rv_q | v1 | de_v[0] | de_v[1] | de_v[2] | vf
              | dh_v[0] | dh_v[1] | dh_v[2];

  // Source increment is folded in as the H cell is read.
  assign hp_c = (32'(ridx_q) == 32'(cfg.source_index))
              ? sat_sum(34'(h_rdata) + 34'(inc)) : h_rdata;

  assign en_c = sat_sum(34'(de_eo[MUL_LAT-1]) - 34'(m_e));
  assign hn_c = sat_sum(34'(dh_hk[MUL_LAT-1]) - 34'(m_h));

  // Multiplier operands.
  always_comb begin
    if (state == ST_TAIL) begin
      me_coeff = 32'(cfg.mur_coeff);
      me_diff  = (tc == T_MUR0) ? 33'(e1n) - 33'(hist[0]) : 33'(ecm1n) - 33'(hist[3]);
      mh_diff  = (tc == T_HD0) ? 33'(e1n) - 33'(e0n) : 33'(ecn) - 33'(ecm1n);
    end else begin
      me_coeff = cfg.e_coeff;
      me_diff  = 33'(hp1) - 33'(hp_prev);
      mh_diff  = 33'(enf) - 33'(en_prev);
    end
    mh_coeff = cfg.h_coeff;
  end

  // Memory ports.
  always_comb begin
    e_we    = 1'b0;
    e_waddr = de_idx[MUL_LAT-1];
    e_wdata = en_c;
    h_we    = 1'b0;
    h_waddr = HA_W'(dh_idx[MUL_LAT-1] - 1'b1);
    h_wdata = hn_c;
    if (state == ST_CLEAR) begin
      e_we    = 1'b1;
      e_waddr = cnt;
      e_wdata = '0;
      h_we    = (32'(cnt) < 32'(CELLS));
      h_waddr = HA_W'(cnt);
      h_wdata = '0;
    end else if (state == ST_TAIL) begin
      if (tc == T_E0) begin
        e_we    = 1'b1;
        e_waddr = '0;
        e_wdata = sat_sum(34'(hist[1]) + 34'(m_e));
      end else if (tc == T_EC) begin
        e_we    = 1'b1;
        e_waddr = EA_W'(CELLS);
        e_wdata = sat_sum(34'(hist[2]) + 34'(m_e));
      end
      if (tc == T_H0) begin
        h_we    = 1'b1;
        h_waddr = '0;
        h_wdata = sat_sum(34'(h0p) - 34'(m_h));
      end else if (tc == T_HC) begin
        h_we    = 1'b1;
        h_waddr = HA_W'(CELLS - 1);
        h_wdata = sat_sum(34'(hcm1p) - 34'(m_h));
      end
    end else begin
      e_we = de_v[MUL_LAT-1];
      h_we = dh_v[MUL_LAT-1];
    end
    if (state == ST_PASS) begin
      e_raddr = cnt;
      h_raddr = HA_W'(cnt);
    end else begin
      e_raddr = EA_W'(cfg.probe_index);
      h_raddr = HA_W'(cfg.probe_index);
    end
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      e_mem[e_waddr] <= e_wdata;
    end
    e_rdata <= e_mem[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      h_mem[h_waddr] <= h_wdata;
    end
    h_rdata <= h_mem[h_raddr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
      tc    <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == EA_W'(CELLS)) begin
            state <= ST_IDLE;
            cnt   <= '0;
          end
        end
        ST_IDLE: begin
          cnt <= '0;
          if (ctl.start) begin
            state <= ST_PASS;
          end
        end
        ST_PASS: begin
          cnt <= cnt + 1'b1;
          if (cnt == EA_W'(CELLS - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          tc <= '0;
          if (!busy) begin
            state <= ST_TAIL;
          end
        end
        ST_TAIL: begin
          tc <= tc + 1'b1;
          if (tc == T_OUT) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (ctl.take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Pipeline valid bits and the Mur history.
  always_ff @(posedge clk) begin
    if (rst) begin
      rv_q <= 1'b0;
      v1   <= 1'b0;
      vf   <= 1'b0;
      for (int k = 0; k < MUL_LAT; k++) begin
        de_v[k] <= 1'b0;
        dh_v[k] <= 1'b0;
      end
      for (int k = 0; k < 4; k++) begin
        hist[k] <= '0;
      end
    end else begin
      rv_q    <= (state == ST_PASS);
      v1      <= rv_q;
      de_v[0] <= v1 && (idx1 != '0);
      dh_v[0] <= vf && (32'(idxf) >= 32'd2);
      for (int k = 1; k < MUL_LAT; k++) begin
        de_v[k] <= de_v[k-1];
        dh_v[k] <= dh_v[k-1];
      end
      vf <= de_v[MUL_LAT-1];
      if (state == ST_TAIL && tc == T_HC) begin
        hist[0] <= e0n;
        hist[1] <= e1n;
        hist[2] <= ecm1n;
        hist[3] <= ecn;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      inc <= inc_in;
    end
    ridx_q <= cnt;
    idx1   <= ridx_q;
    hp1    <= hp_c;
    eo1    <= e_rdata;
    if (v1) begin
      hp_prev <= hp1;
      if (idx1 == '0) begin
        h0p <= hp1;
      end
      if (idx1 == EA_W'(CELLS - 1)) begin
        hcm1p <= hp1;
      end
    end
    de_idx[0] <= idx1;
    de_eo[0]  <= eo1;
    de_hk[0]  <= hp_prev;
    dh_idx[0] <= idxf;
    dh_hk[0]  <= hkf;
    for (int k = 1; k < MUL_LAT; k++) begin
      de_idx[k] <= de_idx[k-1];
      de_eo[k]  <= de_eo[k-1];
      de_hk[k]  <= de_hk[k-1];
      dh_idx[k] <= dh_idx[k-1];
      dh_hk[k]  <= dh_hk[k-1];
    end
    idxf <= de_idx[MUL_LAT-1];
    hkf  <= de_hk[MUL_LAT-1];
    enf  <= en_c;
    if (vf) begin
      en_prev <= enf;
      if (idxf == EA_W'(1)) begin
        e1n <= enf;
      end
      if (idxf == EA_W'(CELLS - 1)) begin
        ecm1n <= enf;
      end
    end
    if (state == ST_TAIL && tc == T_E0) begin
      e0n <= e_wdata;
    end
    if (state == ST_TAIL && tc == T_EC) begin
      ecn <= e_wdata;
    end
    if (state == ST_TAIL && tc == T_OUT) begin
      res.probe_h <= (32'(cfg.probe_index) < 32'(CELLS)) ? h_rdata : '0;
      res.probe_e <= (32'(cfg.probe_index) <= 32'(CELLS)) ? e_rdata : '0;
    end
  end

endmodule

// ===== rtl/core/fdtd_1d_yee_step_mur.sv =====
// ----------------------------------------------------------------------------
// fdtd_1d_yee_step_mur
// One time step of a 1-D Yee grid with first-order Mur boundaries, Q8.24.
// ----------------------------------------------------------------------------
// Each input transaction carries a source increment and runs one full time
// step over the grid held in two on-chip memories (E with CELLS+1 entries,
// H with CELLS entries); each step returns one output transaction with H and
// E at the probe cell. The pass streams one cell per cycle through the single
// read port of each field memory. A drain then empties the read and
// multiplier pipelines, and a boundary tail updates the Mur ends and reads
// the probe cell. The done state then hands the result to the output
// register and returns to idle. If the previous result is still unclaimed
// at that point, the step waits until it is taken. After reset the block
// clears both memories before it raises s_axis_tready; configuration
// writes are taken throughout.
// A finished result waits in an output register, so the next step can be
// accepted while the previous result is still unclaimed.
module fdtd_1d_yee_step_mur (
  input  logic        clk,
  input  logic        rst,
  // Slave side. tdata: [31:0] source_increment.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // Master side. tdata: [31:0] probe_h, [63:32] probe_e.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [fyee_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import fyee_pkg::*;

  cfg_t  cfg;
  ctl_t  ctl;
  stat_t stat;
  res_t  res;

  // Configuration registers. Writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.e_coeff      <= Q_ONE;
      cfg.h_coeff      <= Q_ONE;
      cfg.mur_coeff    <= '0;
      cfg.source_index <= DEFAULT_INDEX;
      cfg.probe_index  <= DEFAULT_INDEX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_E_COEFF:   cfg.e_coeff      <= cfg_data;
        REG_H_COEFF:   cfg.h_coeff      <= cfg_data;
        REG_MUR_COEFF: cfg.mur_coeff    <= cfg_data[25:0];
        REG_SRC_INDEX: cfg.source_index <= cfg_data[9:0];
        REG_PRB_INDEX: cfg.probe_index  <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  // A step starts on an accepted input transaction; the engine hands its
  // result over whenever the output register is empty or being drained.
  assign s_axis_tready = stat.ready;
  assign ctl.start     = s_axis_tvalid && s_axis_tready;
  assign ctl.take      = stat.done && (!m_axis_tvalid || m_axis_tready);

  fyee_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .ctl    (ctl),
    .inc_in (s_axis_tdata),
    .stat   (stat),
    .res    (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctl.take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      m_axis_tdata <= {res.probe_e, res.probe_h};
    end
  end

endmodule

// ===== rtl/core/fyee_chk.sv =====
// ----------------------------------------------------------------------------
// fyee_chk
// Port-level checks for the Yee grid stepper, bound to the top level.
// ----------------------------------------------------------------------------
module fyee_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // Reset starts the clearing pass with nothing on the output.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !s_axis_tready && !m_axis_tvalid)
    else $error("ready or result right after reset");

  // Only one step is in flight: an accepted input closes the input side.
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a step is running");

  // A new result is only ever loaded at the end of a step.
  a_result_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while the engine was idle");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction changed while stalled");

endmodule

bind fdtd_1d_yee_step_mur fyee_chk u_chk (.*);
